/* rtl/core/mdsp_pkg.sv */
package mdsp_pkg;

    // Event codes carried on the result channel
    localparam logic [2:0] EV_OPEN      = 3'd0;
    localparam logic [2:0] EV_KEY       = 3'd1;
    localparam logic [2:0] EV_STR       = 3'd2;
    localparam logic [2:0] EV_INT       = 3'd3;
    localparam logic [2:0] EV_CLOSE     = 3'd4;
    localparam logic [2:0] EV_ERR       = 3'd5;
    localparam logic [2:0] EV_EMPTY_KEY = 3'd6;
    localparam logic [2:0] EV_EMPTY_VAL = 3'd7;

    // Result of one byte, handed from the parser core to the output stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [31:0] int_value;
        logic        last;
    } t_result;

endpackage

/* rtl/core/mdsp_core.sv */
module mdsp_core import mdsp_pkg::*; #(
    parameter int LENGTH_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_DICT    = 4'd1;
    localparam logic [3:0] PH_KEYLEN  = 4'd2;
    localparam logic [3:0] PH_KEYDATA = 4'd3;
    localparam logic [3:0] PH_VALTYPE = 4'd4;
    localparam logic [3:0] PH_VALLEN  = 4'd5;
    localparam logic [3:0] PH_VALDATA = 4'd6;
    localparam logic [3:0] PH_INT     = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    localparam int INT_BYTES = 4;
    localparam logic [1:0] LEN_LAST = 2'(LENGTH_BYTES - 1);
    localparam logic [1:0] INT_LAST = 2'(INT_BYTES - 1);

    localparam logic [7:0] CH_OPEN  = 8'h7B; // '{'
    localparam logic [7:0] CH_CLOSE = 8'h30; // '0'
    localparam logic [7:0] CH_STR   = 8'h73; // 's'
    localparam logic [7:0] CH_INT   = 8'h69; // 'i'

    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_rem,   n_rem;
    logic [1:0]  r_idx,   n_idx;
    logic [31:0] r_word,  n_word;

    logic [31:0] w_gword;
    logic        w_len_done;
    logic        w_int_done;
    logic        w_lst;
    t_result     w_res;

    // OR the byte into the lane picked by the byte index
    always_comb begin
        w_gword = r_word;
        for (int k = 0; k < 4; k++) begin
            if (r_idx == 2'(k)) begin
                w_gword[8*k +: 8] = r_word[8*k +: 8] | i_byte;
            end
        end
    end

    assign w_len_done = (r_idx >= LEN_LAST);
    assign w_int_done = (r_idx >= INT_LAST);
    assign w_lst      = (r_rem <= 32'd1);

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_idx   = r_idx;
        n_word  = r_word;
        w_res   = '0;
        if (i_accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == CH_OPEN) begin
                        n_phase         = PH_DICT;
                        w_res.valid     = 1'b1;
                        w_res.event_res = EV_OPEN;
                    end else begin
                        n_phase         = PH_ERROR;
                        w_res.valid     = 1'b1;
                        w_res.event_res = EV_ERR;
                    end
                end
                PH_DICT: begin
                    if (i_byte == CH_CLOSE) begin
                        n_phase         = PH_IDLE;
                        w_res.valid     = 1'b1;
                        w_res.event_res = EV_CLOSE;
                    end else if (i_byte == CH_STR) begin
                        n_phase = PH_KEYLEN;
                        n_idx   = 2'd0;
                        n_word  = '0;
                    end else begin
                        n_phase         = PH_ERROR;
                        w_res.valid     = 1'b1;
                        w_res.event_res = EV_ERR;
                    end
                end
                PH_KEYLEN, PH_VALLEN: begin
                    n_word = w_gword;
                    if (!w_len_done) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        n_idx = 2'd0;
                        n_rem = w_gword;
                        if (w_gword == 32'd0) begin
                            w_res.valid = 1'b1;
                            if (r_phase == PH_KEYLEN) begin
                                n_phase         = PH_VALTYPE;
                                w_res.event_res = EV_EMPTY_KEY;
                            end else begin
                                n_phase         = PH_DICT;
                                w_res.event_res = EV_EMPTY_VAL;
                            end
                        end else begin
                            n_phase = (r_phase == PH_KEYLEN) ? PH_KEYDATA : PH_VALDATA;
                        end
                    end
                end
                PH_KEYDATA, PH_VALDATA: begin
                    n_rem           = w_lst ? 32'd0 : r_rem - 32'd1;
                    w_res.valid     = 1'b1;
                    w_res.data_byte = i_byte;
                    w_res.last      = w_lst;
                    if (r_phase == PH_KEYDATA) begin
                        w_res.event_res = EV_KEY;
                        if (w_lst) begin
                            n_phase = PH_VALTYPE;
                        end
                    end else begin
                        w_res.event_res = EV_STR;
                        if (w_lst) begin
                            n_phase = PH_DICT;
                        end
                    end
                end
                PH_VALTYPE: begin
                    n_idx  = 2'd0;
                    n_word = '0;
                    if (i_byte == CH_STR) begin
                        n_phase = PH_VALLEN;
                    end else if (i_byte == CH_INT) begin
                        n_phase = PH_INT;
                    end else begin
                        n_phase         = PH_ERROR;
                        w_res.valid     = 1'b1;
                        w_res.event_res = EV_ERR;
                    end
                end
                PH_INT: begin
                    n_word = w_gword;
                    if (!w_int_done) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        n_idx           = 2'd0;
                        n_phase         = PH_DICT;
                        w_res.valid     = 1'b1;
                        w_res.event_res = EV_INT;
                        w_res.int_value = w_gword;
                    end
                end
                PH_ERROR: begin
                    n_phase = PH_ERROR;
                end
                default: begin
                    n_phase         = PH_ERROR;
                    w_res.valid     = 1'b1;
                    w_res.event_res = EV_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_idx   <= '0;
            r_word  <= '0;
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_idx   <= n_idx;
            r_word  <= n_word;
        end
    end

    assign o_res = w_res;

    // error is sticky
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERROR |=> r_phase == PH_ERROR)
        else $error("error phase left without reset");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERROR |-> !o_res.valid)
        else $error("result produced after error");

    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_accept)
        else $error("result without a byte transfer");

    a_data_phase_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEYDATA || r_phase == PH_VALDATA) |-> r_rem != 32'd0)
        else $error("data phase with nothing left");

endmodule

/* rtl/core/marshal_dict_stream_parser.sv */
// Streaming parser for marshalled string dictionaries, one byte per transfer.
// Input channel: i_in_valid / o_in_ready carry i_in_byte, the raw stream.
// Output channel: o_out_valid / i_out_ready carry one event per result:
//   o_event_res (open, key byte, string byte, integer, close, error,
//   empty key, empty value), o_data_byte and o_last for key/string bytes,
//   o_int_value for completed integers; unused fields read as zero.
// Length, integer and 's'/'i' type bytes give no result, but the last byte of
//   an integer or of a zero length does. A result shows in the cycle after its byte.
// Throughput: one byte per cycle; the state machine and the output register
//   form a single registered stage, so a byte is taken whenever the output
//   register is empty or is being drained in the same cycle.
// Receiver stall: the pending result holds in the output register and
//   o_in_ready drops until it is taken; no byte is lost or dropped.
// Any unexpected byte gives one error event; the parser then swallows every
//   later byte silently until reset.
// Reset (synchronous, active low): parser returns to awaiting '{', output
//   register empties; no clearing pass, ready on the first cycle after.
// LENGTH_BYTES sets the size of the little-endian length fields (1 to 4).
module marshal_dict_stream_parser import mdsp_pkg::*; #(
    parameter int LENGTH_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_int_value,
    output logic        o_last
);

    logic    w_accept;
    t_result w_res;

    logic        r_out_valid;
    logic [2:0]  r_event_res;
    logic [7:0]  r_data_byte;
    logic [31:0] r_int_value;
    logic        r_last;

    // output register can take a new result when empty or draining now
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    mdsp_core #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in_byte),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= w_res.valid;
        end
    end

    // payload only loads with a fresh result
    always_ff @(posedge i_clk) begin
        if (o_in_ready && w_res.valid) begin
            r_event_res <= w_res.event_res;
            r_data_byte <= w_res.data_byte;
            r_int_value <= w_res.int_value;
            r_last      <= w_res.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event_res;
    assign o_data_byte = r_data_byte;
    assign o_int_value = r_int_value;
    assign o_last      = r_last;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_KEY && o_event_res != EV_STR)
        |-> (o_data_byte == 8'd0 && !o_last))
        else $error("byte fields set on a non-byte event");

    a_int_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_INT) |-> o_int_value == 32'd0)
        else $error("integer field set on a non-integer event");

endmodule

/* dv/mdsp_tb_pkg.sv */
package mdsp_tb_pkg;

    // Tag bytes of the marshalled stream
    localparam logic [7:0] TAG_DICT_OPEN  = 8'h7B;  // '{'
    localparam logic [7:0] TAG_DICT_CLOSE = 8'h30;  // '0'
    localparam logic [7:0] TAG_STRING     = 8'h73;  // 's'
    localparam logic [7:0] TAG_INT        = 8'h69;  // 'i'

endpackage

/* dv/marshal_event_checker.sv */
module marshal_event_checker import mdsp_pkg::*, mdsp_tb_pkg::*; #(
    parameter int LENGTH_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_event_res,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_int_value,
    input  logic        i_last,
    output int          o_outstanding,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INT_BYTES   = 4;
    localparam int MAX_REPORTS = 50;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DICT,
        PH_KEY_LEN,
        PH_KEY_DATA,
        PH_VAL_TYPE,
        PH_VAL_LEN,
        PH_VAL_DATA,
        PH_INT,
        PH_ERROR
    } t_phase;

    t_phase      phase;
    logic [31:0] bytes_left;
    logic [1:0]  word_idx;
    logic [31:0] word_acc;

    t_result pending_events[$];
    int      mismatches = 0;

    function automatic void reset_parser();
        phase      = PH_IDLE;
        bytes_left = '0;
        word_idx   = '0;
        word_acc   = '0;
    endfunction

    function automatic t_result make_event(input logic [2:0] ev, input logic [7:0] data,
                                           input logic [31:0] value, input logic lst);
        t_result r;
        r.valid     = 1'b1;
        r.event_res = ev;
        r.data_byte = data;
        r.int_value = value;
        r.last      = lst;
        return r;
    endfunction

    // Bad byte: one error event, then silence until reset
    function automatic t_result parse_error();
        phase = PH_ERROR;
        return make_event(EV_ERR, 8'h00, 32'h0, 1'b0);
    endfunction

    // Little-endian word assembly; true once count bytes are in
    function automatic logic gather(input logic [7:0] b, input int count);
        word_acc = word_acc | ({24'h0, b} << (8 * word_idx));
        if (int'(word_idx) + 1 >= count) begin
            word_idx = '0;
            return 1'b1;
        end
        word_idx = word_idx + 2'd1;
        return 1'b0;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        logic    lst;
        r = '0;
        case (phase)
            PH_IDLE: begin
                if (b != TAG_DICT_OPEN) begin
                    r = parse_error();
                end else begin
                    phase = PH_DICT;
                    r = make_event(EV_OPEN, 8'h00, 32'h0, 1'b0);
                end
            end
            PH_DICT: begin
                if (b == TAG_DICT_CLOSE) begin
                    phase = PH_IDLE;
                    r = make_event(EV_CLOSE, 8'h00, 32'h0, 1'b0);
                end else if (b == TAG_STRING) begin
                    word_idx = '0;
                    word_acc = '0;
                    phase    = PH_KEY_LEN;
                end else begin
                    r = parse_error();
                end
            end
            PH_KEY_LEN: begin
                if (gather(b, LENGTH_BYTES)) begin
                    bytes_left = word_acc;
                    if (bytes_left == 0) begin
                        phase = PH_VAL_TYPE;
                        r = make_event(EV_EMPTY_KEY, 8'h00, 32'h0, 1'b0);
                    end else begin
                        phase = PH_KEY_DATA;
                    end
                end
            end
            PH_KEY_DATA: begin
                lst        = (bytes_left <= 1);
                bytes_left = lst ? 32'h0 : bytes_left - 1;
                if (lst) phase = PH_VAL_TYPE;
                r = make_event(EV_KEY, b, 32'h0, lst);
            end
            PH_VAL_TYPE: begin
                word_idx = '0;
                word_acc = '0;
                if (b == TAG_STRING) phase = PH_VAL_LEN;
                else if (b == TAG_INT) phase = PH_INT;
                else r = parse_error();
            end
            PH_VAL_LEN: begin
                if (gather(b, LENGTH_BYTES)) begin
                    bytes_left = word_acc;
                    if (bytes_left == 0) begin
                        phase = PH_DICT;
                        r = make_event(EV_EMPTY_VAL, 8'h00, 32'h0, 1'b0);
                    end else begin
                        phase = PH_VAL_DATA;
                    end
                end
            end
            PH_VAL_DATA: begin
                lst        = (bytes_left <= 1);
                bytes_left = lst ? 32'h0 : bytes_left - 1;
                if (lst) phase = PH_DICT;
                r = make_event(EV_STR, b, 32'h0, lst);
            end
            PH_INT: begin
                if (gather(b, INT_BYTES)) begin
                    phase = PH_DICT;
                    r = make_event(EV_INT, 8'h00, word_acc, 1'b0);
                end
            end
            PH_ERROR: ;
            default: r = parse_error();
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            reset_parser();
            pending_events.delete();
        end else begin
            // drain first: a result never leaves in the cycle its byte arrives
            if (i_out_valid && i_out_ready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event %0d", i_event_res));
                end else begin
                    want = pending_events.pop_front();
                    if (i_event_res !== want.event_res)
                        report_mismatch($sformatf("event %0d, expected %0d",
                                                  i_event_res, want.event_res));
                    if (i_data_byte !== want.data_byte)
                        report_mismatch($sformatf("data 0x%02h, expected 0x%02h",
                                                  i_data_byte, want.data_byte));
                    if (i_int_value !== want.int_value)
                        report_mismatch($sformatf("int 0x%08h, expected 0x%08h",
                                                  i_int_value, want.int_value));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  i_last, want.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                got = parse_byte(i_in_byte);
                if (got.valid) pending_events.push_back(got);
            end
        end
        o_outstanding <= pending_events.size();
        o_fail_count  <= mismatches;
    end

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mdsp_pkg::*;
    import mdsp_tb_pkg::*;

    localparam int LENGTH_BYTES   = 4;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int RANDOM_TARGET  = 530;   // minimum stream length before the broken tail
    localparam int NOISE_BYTES    = 20;    // swallowed silently after the error
    localparam int PAUSE_AT       = 120;   // sender waits for every result here
    localparam int HOLD_AT        = 200;   // receiver starts its long hold-off here
    localparam int HOLD_CYCLES    = 60;
    localparam int CALM_FROM      = 330;   // no idling on either side in this window
    localparam int CALM_TO        = 430;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [31:0] int_value;
    logic        out_last;

    int results_owed;
    int fail_count;

    logic [7:0] stream_bytes[$];
    int         sent_count = 0;
    int         cycle_count = 0;

    marshal_dict_stream_parser #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_byte   (in_byte),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_event_res (event_res),
        .o_data_byte (data_byte),
        .o_int_value (int_value),
        .o_last      (out_last)
    );

    marshal_event_checker #(
        .LENGTH_BYTES (LENGTH_BYTES)
    ) event_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_event_res   (event_res),
        .i_data_byte   (data_byte),
        .i_int_value   (int_value),
        .i_last        (out_last),
        .o_outstanding (results_owed),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stream construction. The error state sticks until reset and reset
    // is only applied once, so everything up to the tail is well formed;
    // the single broken construct and the noise behind it come last.
    // ------------------------------------------------------------------

    // Little-endian length field, LENGTH_BYTES wide
    function automatic void add_length(input int unsigned n);
        for (int i = 0; i < LENGTH_BYTES; i++) stream_bytes.push_back(8'(n >> (8 * i)));
    endfunction

    // 's', length, then n random content bytes
    function automatic void add_string(input int unsigned n);
        stream_bytes.push_back(TAG_STRING);
        add_length(n);
        repeat (n) stream_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // Mostly short strings, some empty, the odd longer one
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return 0;
        if (r < 88) return $urandom_range(6, 1);
        return $urandom_range(40, 7);
    endfunction

    function automatic logic [31:0] pick_int();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_entry();
        logic [31:0] v;
        add_string(pick_length());
        if ($urandom_range(1) == 1) begin
            v = pick_int();
            stream_bytes.push_back(TAG_INT);
            for (int i = 0; i < 4; i++) stream_bytes.push_back(v[8*i +: 8]);
        end else begin
            add_string(pick_length());
        end
    endfunction

    function automatic void add_dict(input int entries);
        stream_bytes.push_back(TAG_DICT_OPEN);
        repeat (entries) add_entry();
        stream_bytes.push_back(TAG_DICT_CLOSE);
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        do r = 8'($urandom_range(255)); while (r == a || r == b);
        return r;
    endfunction

    // Hand-picked opening: empty dictionary, empty key with the largest
    // integer, a one-byte key of zero with an empty string value.
    function automatic void add_directed();
        add_dict(0);
        stream_bytes.push_back(TAG_DICT_OPEN);
        add_string(0);
        stream_bytes.push_back(TAG_INT);
        repeat (4) stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(TAG_STRING);
        add_length(1);
        stream_bytes.push_back(8'h00);
        add_string(0);
        stream_bytes.push_back(TAG_DICT_CLOSE);
    endfunction

    // One broken construct, picked at random: stray byte between
    // dictionaries, bad tag inside a dictionary, or bad value type.
    function automatic void add_broken_tail();
        case ($urandom_range(2))
            0: stream_bytes.push_back(byte_other_than(TAG_DICT_OPEN, TAG_DICT_OPEN));
            1: begin
                stream_bytes.push_back(TAG_DICT_OPEN);
                stream_bytes.push_back(byte_other_than(TAG_DICT_CLOSE, TAG_STRING));
            end
            default: begin
                stream_bytes.push_back(TAG_DICT_OPEN);
                add_string(1);
                stream_bytes.push_back(byte_other_than(TAG_STRING, TAG_INT));
            end
        endcase
        repeat (NOISE_BYTES) stream_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic bit calm_stretch();
        return sent_count >= CALM_FROM && sent_count < CALM_TO;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Valid is raised only once per step and held until the
    // transfer; random idle cycles in between, none in the calm window.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while (!calm_stretch() && $urandom_range(99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait until every predicted event has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        while (stream_bytes.size() < RANDOM_TARGET) add_dict($urandom_range(5));
        add_broken_tail();

        for (int k = 0; k < stream_bytes.size(); k++) begin
            if (k == PAUSE_AT) wait_for_drain();
            send_byte(stream_bytes[k]);
            sent_count = k + 1;
        end
        wait_for_drain();
        // the block may still be busy on a byte that gives no event
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure, one long hold-off while the
    // sender keeps offering so the output register fills and the input
    // stalls, and no back-pressure in the calm window.
    // ------------------------------------------------------------------
    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && sent_count >= HOLD_AT) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end else if (calm_stretch()) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    // Watchdog against a hung handshake
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
